/* hdl/stereo_feedback_delay_macros.svh */
// Assertion macros for the stereo feedback delay.
// Included by the top-level RTL file, which carries concurrent checks; no other dependencies.
`ifndef STEREO_FEEDBACK_DELAY_MACROS_SVH
`define STEREO_FEEDBACK_DELAY_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SFD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfd same-cycle check failed");
// next-cycle implication
`define SFD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfd next-cycle check failed");
`else
`define SFD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SFD_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* hdl/sfd_pkg.sv */
// Shared types, constants and arithmetic helpers for the stereo feedback delay.
// No dependencies; used by the interfaces and the RTL modules of the block.
package sfd_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int DELAY_W   = 17;
    localparam int GAIN_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int OPND_W    = 19;
    localparam int PROD_W    = 36;
    localparam int RND_W     = 21;

    localparam int DELAY_RESET = 24000;
    localparam logic [GAIN_W-1:0] DRY_RESET  = 16'd32768;
    localparam logic [GAIN_W-1:0] WET_RESET  = 16'd16384;
    localparam logic [GAIN_W-1:0] FB_RESET   = 16'd6554;
    localparam logic [GAIN_W-1:0] OG_RESET   = 16'd10362;

    localparam logic [CFG_IDX_W-1:0] CFG_DELAY  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DRY    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WET    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FB     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTG   = 3'd4;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_WET   = 6'b000010,
        S_DRY   = 6'b000100,
        S_FB    = 6'b001000,
        S_OGAIN = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    // per-cycle strobes from the sequencer to both channel datapaths
    typedef struct packed {
        logic load_in;
        logic mul_wet;
        logic mul_dry;
        logic mul_fb;
        logic mul_out;
        logic load_out;
    } chan_ctrl_t;

    // floor((x + 2^14) / 2^15)
    function automatic logic signed [RND_W-1:0] round_q15(input logic signed [PROD_W-1:0] x);
        logic signed [PROD_W-1:0] t;
        t = x + 36'sd16384;
        return t[PROD_W-1:15];
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [RND_W-1:0] x);
        logic signed [SAMPLE_W-1:0] r;
        if (x > 21'sd32767)
            r = 16'sh7fff;
        else if (x < -21'sd32768)
            r = 16'sh8000;
        else
            r = x[SAMPLE_W-1:0];
        return r;
    endfunction

endpackage

/* hdl/sfd_in_if.sv */
// Input frame channel: valid/ready handshake carrying one stereo sample pair.
// Depends on sfd_pkg for the sample width.
interface sfd_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [sfd_pkg::SAMPLE_W-1:0] left_in;
    logic signed [sfd_pkg::SAMPLE_W-1:0] right_in;

    modport source (output valid, output left_in, output right_in, input ready);
    modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

/* hdl/sfd_out_if.sv */
// Output frame channel: valid/ready handshake carrying one stereo result pair.
// Depends on sfd_pkg for the sample width.
interface sfd_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [sfd_pkg::SAMPLE_W-1:0] left_out;
    logic signed [sfd_pkg::SAMPLE_W-1:0] right_out;

    modport source (output valid, output left_out, output right_out, input ready);
    modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

/* hdl/stereo_feedback_delay.sv */
// After the input transfer, the one multiplier per channel runs the wet, dry, feedback
// and output-gain products in turn, then loads the result; only then is a new frame taken.
// A delay register write starts a modulo reduction; ready is low for the cycle after.
// Reset: control state idle, registers at defaults, write position zero. Store
// entries read as zero until written, tracked by a fill count; no clearing pass.
`include "stereo_feedback_delay_macros.svh"

module stereo_feedback_delay #(
    parameter int STORE_DEPTH = 131072
) (
    input  logic                               clk,
    input  logic                               rst_n,
    sfd_in_if.sink                             samples_in,
    sfd_out_if.source                          samples_out,
    input  logic                               cfg_we,
    input  logic [sfd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sfd_pkg::DELAY_W-1:0]        cfg_data
);

    localparam int AW  = $clog2(STORE_DEPTH);
    localparam int AW1 = AW + 1;
    localparam int FW  = $clog2(STORE_DEPTH + 1);
    localparam logic [AW1-1:0] DEPTH_W = AW1'(STORE_DEPTH);
    localparam logic [FW-1:0]  FULL_W  = FW'(STORE_DEPTH);
    localparam logic [AW-1:0]  LAST_W  = AW'(STORE_DEPTH - 1);
    localparam int GW = sfd_pkg::GAIN_W;

    sfd_pkg::state_t     state_reg, state_next;
    sfd_pkg::chan_ctrl_t ctrl;

    logic [GW-1:0] dry_reg, wet_reg, fb_reg, og_reg;
    logic [AW-1:0] wr_pos_reg, wr_pos_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic          rd_ok_reg;
    logic          out_valid_reg, out_valid_next;

    logic          accept;
    logic          red_busy;
    logic [AW-1:0] delay_mod;
    logic [AW1-1:0] rd_sum;
    logic [AW1-1:0] rd_wrap;
    logic [AW-1:0] rd_addr;
    logic [GW-1:0] gain_sel;

    sfd_delay_mod #(.STORE_DEPTH(STORE_DEPTH)) u_delay_mod (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cfg_we && (cfg_index == sfd_pkg::CFG_DELAY)),
        .value  (cfg_data),
        .busy   (red_busy),
        .result (delay_mod)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dry_reg <= sfd_pkg::DRY_RESET;
            wet_reg <= sfd_pkg::WET_RESET;
            fb_reg  <= sfd_pkg::FB_RESET;
            og_reg  <= sfd_pkg::OG_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sfd_pkg::CFG_DRY:  dry_reg <= cfg_data[GW-1:0];
                sfd_pkg::CFG_WET:  wet_reg <= cfg_data[GW-1:0];
                sfd_pkg::CFG_FB:   fb_reg  <= cfg_data[GW-1:0];
                sfd_pkg::CFG_OUTG: og_reg  <= cfg_data[GW-1:0];
                default: ;
            endcase
        end
    end

    // read position = write position - delay, wrapped into the store
    assign rd_sum  = AW1'(wr_pos_reg) + DEPTH_W - AW1'(delay_mod);
    assign rd_wrap = (rd_sum >= DEPTH_W) ? (rd_sum - DEPTH_W) : rd_sum;
    assign rd_addr = rd_wrap[AW-1:0];

    assign samples_in.ready = (state_reg == sfd_pkg::S_IDLE) && !red_busy;
    assign accept           = samples_in.valid && samples_in.ready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        ctrl           = '0;
        gain_sel       = '0;
        if (out_valid_reg && samples_out.ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            sfd_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    ctrl.load_in = 1'b1;
                    state_next   = sfd_pkg::S_WET;
                end
            end
            sfd_pkg::S_WET:
            begin
                ctrl.mul_wet = 1'b1;
                gain_sel     = wet_reg;
                state_next   = sfd_pkg::S_DRY;
            end
            sfd_pkg::S_DRY:
            begin
                ctrl.mul_dry = 1'b1;
                gain_sel     = dry_reg;
                state_next   = sfd_pkg::S_FB;
            end
            sfd_pkg::S_FB:
            begin
                ctrl.mul_fb = 1'b1;
                gain_sel    = fb_reg;
                state_next  = sfd_pkg::S_OGAIN;
            end
            sfd_pkg::S_OGAIN:
            begin
                ctrl.mul_out = 1'b1;
                gain_sel     = og_reg;
                state_next   = sfd_pkg::S_DONE;
            end
            sfd_pkg::S_DONE:
            begin
                // load only once the previous result has been transferred
                if (!out_valid_reg || samples_out.ready)
                begin
                    ctrl.load_out  = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = sfd_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = sfd_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        wr_pos_next = wr_pos_reg;
        fill_next   = fill_reg;
        if (ctrl.mul_out)
        begin
            wr_pos_next = (wr_pos_reg == LAST_W) ? '0 : wr_pos_reg + AW'(1);
            if (fill_reg != FULL_W)
            begin
                fill_next = fill_reg + FW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sfd_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
            wr_pos_reg    <= '0;
            fill_reg      <= '0;
            rd_ok_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            wr_pos_reg    <= wr_pos_next;
            fill_reg      <= fill_next;
            if (accept)
            begin
                rd_ok_reg <= (FW'(rd_addr) < fill_reg);
            end
        end
    end

    sfd_channel #(.STORE_DEPTH(STORE_DEPTH)) u_left (
        .clk        (clk),
        .ctrl       (ctrl),
        .rd_addr    (rd_addr),
        .rd_ok      (rd_ok_reg),
        .wr_addr    (wr_pos_reg),
        .gain       (gain_sel),
        .sample_in  (samples_in.left_in),
        .sample_out (samples_out.left_out)
    );

    sfd_channel #(.STORE_DEPTH(STORE_DEPTH)) u_right (
        .clk        (clk),
        .ctrl       (ctrl),
        .rd_addr    (rd_addr),
        .rd_ok      (rd_ok_reg),
        .wr_addr    (wr_pos_reg),
        .gain       (gain_sel),
        .sample_in  (samples_in.right_in),
        .sample_out (samples_out.right_out)
    );

    assign samples_out.valid = out_valid_reg;

    `SFD_ASSERT_NXT(a_accept_starts, clk, rst_n, accept, state_reg == sfd_pkg::S_WET)
    `SFD_ASSERT_IMP(a_busy_blocks, clk, rst_n, red_busy, !samples_in.ready)
    `SFD_ASSERT_IMP(a_fill_bound, clk, rst_n, 1'b1, fill_reg <= FULL_W)
    `SFD_ASSERT_NXT(a_wr_advances, clk, rst_n, ctrl.mul_out, wr_pos_reg != $past(wr_pos_reg))
    `SFD_ASSERT_IMP(a_load_free, clk, rst_n, ctrl.load_out, !out_valid_reg || samples_out.ready)

endmodule

/* hdl/sfd_delay_mod.sv */
// Reduction of the delay register modulo the store depth by reciprocal multiplication.
// Depends on sfd_pkg; the quotient is registered first, then the remainder from it.
module sfd_delay_mod #(
    parameter int STORE_DEPTH = 131072,
    localparam int AW = $clog2(STORE_DEPTH)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [sfd_pkg::DELAY_W-1:0]  value,
    output logic                         busy,
    output logic [AW-1:0]                result
);

    localparam int AW1 = AW + 1;
    localparam int NW  = sfd_pkg::DELAY_W;
    localparam int MW  = NW + 2;
    localparam int QW  = NW + AW1;
    localparam int SH  = NW + AW;
    // ceil(2^SH / depth): the quotient is exact for every NW-bit value
    localparam longint unsigned RECIP_L =
        ((64'd1 << SH) + 64'(STORE_DEPTH) - 64'd1) / 64'(STORE_DEPTH);
    localparam logic [MW-1:0]  RECIP     = MW'(RECIP_L);
    localparam logic [AW1-1:0] DEPTH_W   = AW1'(STORE_DEPTH);
    localparam logic [AW-1:0]  RESET_MOD = AW'(sfd_pkg::DELAY_RESET % STORE_DEPTH);

    logic                 busy_reg, busy_next;
    logic [NW-1:0]        val_reg, val_next;
    logic [NW-1:0]        quot_reg, quot_next;
    logic [AW-1:0]        rem_reg, rem_next;
    logic [NW+MW-1:0]     prod_full;
    logic [QW-1:0]        qd_full;
    logic [QW-1:0]        rem_full;

    assign prod_full = value * RECIP;
    assign qd_full   = quot_reg * DEPTH_W;
    assign rem_full  = QW'(val_reg) - qd_full;

    always_comb
    begin
        busy_next = 1'b0;
        val_next  = val_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            val_next  = value;
            quot_next = NW'(prod_full >> SH);
        end
        else if (busy_reg)
        begin
            rem_next = rem_full[AW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            val_reg  <= '0;
            quot_reg <= '0;
            rem_reg  <= RESET_MOD;
        end
        else
        begin
            busy_reg <= busy_next;
            val_reg  <= val_next;
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
        end
    end

    assign busy   = busy_reg;
    assign result = rem_reg;

endmodule

/* hdl/sfd_channel.sv */
// One channel: circular sample store plus a shared multiply-accumulate datapath.
// Depends on sfd_pkg for widths, control strobes, rounding and saturation.
module sfd_channel #(
    parameter int STORE_DEPTH = 131072,
    localparam int AW = $clog2(STORE_DEPTH)
) (
    input  logic                                clk,
    input  sfd_pkg::chan_ctrl_t                 ctrl,
    input  logic [AW-1:0]                       rd_addr,
    input  logic                                rd_ok,
    input  logic [AW-1:0]                       wr_addr,
    input  logic [sfd_pkg::GAIN_W-1:0]          gain,
    input  logic signed [sfd_pkg::SAMPLE_W-1:0] sample_in,
    output logic signed [sfd_pkg::SAMPLE_W-1:0] sample_out
);

    localparam int SW = sfd_pkg::SAMPLE_W;
    localparam int OW = sfd_pkg::OPND_W;

    logic signed [SW-1:0] mem [STORE_DEPTH];

    logic signed [SW-1:0]                   q_reg;
    logic signed [SW-1:0]                   in_reg;
    logic signed [SW-1:0]                   d_reg;
    logic signed [OW-1:0]                   mix_reg;
    logic signed [sfd_pkg::PROD_W-1:0]      acc_reg;
    logic signed [SW-1:0]                   out_reg;

    logic signed [SW-1:0]                   d_sel;
    logic signed [OW-1:0]                   opnd;
    logic signed [sfd_pkg::GAIN_W:0]        gain_s;
    logic signed [sfd_pkg::PROD_W-1:0]      prod;
    logic signed [sfd_pkg::RND_W-1:0]       rq;
    logic signed [sfd_pkg::RND_W-1:0]       fb_sum;
    logic signed [SW-1:0]                   wr_data;

    // entries not yet written since reset read as zero
    assign d_sel = rd_ok ? q_reg : '0;

    always_comb
    begin
        if (ctrl.mul_wet)
            opnd = OW'(d_sel);
        else if (ctrl.mul_dry)
            opnd = OW'(in_reg);
        else if (ctrl.mul_fb)
            opnd = OW'(d_reg);
        else
            opnd = mix_reg;
    end

    assign gain_s  = $signed({1'b0, gain});
    assign prod    = gain_s * opnd;
    assign rq      = sfd_pkg::round_q15(acc_reg);
    assign fb_sum  = rq + sfd_pkg::RND_W'(in_reg);
    assign wr_data = sfd_pkg::sat16(fb_sum);

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_out)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctrl.load_in)
        begin
            q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_in)
        begin
            in_reg <= sample_in;
        end
        if (ctrl.mul_wet)
        begin
            d_reg   <= d_sel;
            acc_reg <= prod;
        end
        if (ctrl.mul_dry)
        begin
            acc_reg <= acc_reg + prod;
        end
        if (ctrl.mul_fb)
        begin
            mix_reg <= rq[OW-1:0];
            acc_reg <= prod;
        end
        if (ctrl.mul_out)
        begin
            acc_reg <= prod;
        end
        if (ctrl.load_out)
        begin
            out_reg <= sfd_pkg::sat16(rq);
        end
    end

    assign sample_out = out_reg;

endmodule
